### rtl/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property that must hold whenever reset is released.
`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Clocked condition that must never be seen while reset is released.
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

`endif

### rtl/srb_pkg.sv
package srb_pkg;

	// Default configuration of the block.
	localparam int unsigned MAX_PASSES_DEF = 48;
	localparam int unsigned FRAC_BITS_DEF  = 16;

	// Fixed field widths.
	localparam int unsigned DATA_W = 32;
	localparam int unsigned PASS_W = 6;
	localparam int unsigned SQ_W   = 64;

	// Result of one search, handed from the sequencer to the output register.
	typedef struct packed {
		logic [DATA_W-1:0] root;
		logic [PASS_W-1:0] passes;
		logic              converged;
	} srb_result_t;

endpackage

### rtl/srb_square.sv
module srb_square import srb_pkg::*; (
	input  logic              clk,
	input  logic              en,
	input  logic [DATA_W-1:0] operand,
	output logic [SQ_W-1:0]   product
);

	logic [SQ_W-1:0] product_q;

	// Full-precision square, registered before use.
	always_ff @(posedge clk) begin
		if (en) begin
			product_q <= SQ_W'(operand) * SQ_W'(operand);
		end
	end

	assign product = product_q;

endmodule

### rtl/srb_seq.sv
module srb_seq import srb_pkg::*; #(
	parameter int unsigned MAX_PASSES = MAX_PASSES_DEF,
	parameter int unsigned FRAC_BITS  = FRAC_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [DATA_W-1:0] value,
	input  logic [DATA_W-1:0] tolerance,
	output logic              idle,
	output logic              res_valid,
	input  logic              res_ready,
	output srb_result_t       res,
	output logic              sq_en,
	output logic [DATA_W-1:0] sq_operand,
	input  logic [SQ_W-1:0]   sq_product
);

	`include "assert_macros.svh"

	localparam logic [DATA_W-1:0] OneFx   = DATA_W'(64'd1 << FRAC_BITS);
	localparam logic [PASS_W-1:0] PassMax = PASS_W'(MAX_PASSES);

	typedef enum logic [2:0] {
		S_IDLE,
		S_LOAD,
		S_MUL,
		S_CMP,
		S_FIN
	} state_t;

	state_t            state_q;
	logic [DATA_W-1:0] value_q;
	logic [DATA_W-1:0] low_q;
	logic [DATA_W-1:0] high_q;
	logic [DATA_W-1:0] mid_q;
	logic [PASS_W-1:0] pass_q;
	logic [SQ_W-1:0]   target_q;
	logic [SQ_W-1:0]   lo_lim_q;
	logic [SQ_W-1:0]   hi_lim_q;
	srb_result_t       res_q;

	logic [SQ_W-1:0]   target;
	logic [SQ_W-1:0]   tol_sh;
	logic [SQ_W-1:0]   lo_lim;
	logic [SQ_W-1:0]   hi_lim;
	logic [DATA_W-1:0] high_init;
	logic              in_tol;
	logic              below;
	logic [DATA_W-1:0] mid_up;
	logic [DATA_W-1:0] mid_dn;
	logic [PASS_W-1:0] pass_nx;

	// Search window set up from the radicand and the tolerance. A lower limit
	// that would go negative is clamped to zero, which every square meets.
	always_comb begin
		target    = SQ_W'(value_q) << FRAC_BITS;
		tol_sh    = SQ_W'(tolerance) << FRAC_BITS;
		lo_lim    = (target >= tol_sh) ? (target - tol_sh) : '0;
		hi_lim    = target + tol_sh;
		high_init = (value_q > OneFx) ? value_q : OneFx;
	end

	// Per-pass decisions on the registered square, and both candidate
	// midpoints formed alongside so that only a select follows the compare.
	always_comb begin
		in_tol  = (sq_product >= lo_lim_q) && (sq_product <= hi_lim_q);
		below   = sq_product < target_q;
		mid_up  = DATA_W'(((DATA_W+1)'(mid_q) + (DATA_W+1)'(high_q)) >> 1);
		mid_dn  = DATA_W'(((DATA_W+1)'(low_q) + (DATA_W+1)'(mid_q)) >> 1);
		pass_nx = pass_q + PASS_W'(1);
	end

	// Sequencer and bisection registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			value_q  <= '0;
			low_q    <= '0;
			high_q   <= '0;
			mid_q    <= '0;
			pass_q   <= '0;
			target_q <= '0;
			lo_lim_q <= '0;
			hi_lim_q <= '0;
			res_q    <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						value_q <= value;
						state_q <= S_LOAD;
					end
				end
				S_LOAD: begin
					target_q <= target;
					lo_lim_q <= lo_lim;
					hi_lim_q <= hi_lim;
					low_q    <= '0;
					high_q   <= high_init;
					mid_q    <= '0;
					pass_q   <= '0;
					// A zero radicand is an exact square of the lower bound;
					// exactly one is an exact square of the upper bound. No
					// later bound can square exactly, so only this pass checks.
					if (value_q == '0) begin
						res_q   <= '{root: '0, passes: '0, converged: 1'b1};
						state_q <= S_FIN;
					end else if (value_q == OneFx) begin
						res_q   <= '{root: OneFx, passes: '0, converged: 1'b1};
						high_q  <= OneFx;
						state_q <= S_FIN;
					end else begin
						mid_q   <= high_init >> 1;
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					state_q <= S_CMP;
				end
				S_CMP: begin
					if (in_tol) begin
						res_q   <= '{root: mid_q, passes: pass_q, converged: 1'b1};
						state_q <= S_FIN;
					end else begin
						pass_q <= pass_nx;
						if (below) begin
							low_q <= mid_q;
						end else begin
							high_q <= mid_q;
						end
						if (pass_nx == PassMax) begin
							res_q   <= '{root: mid_q, passes: pass_nx, converged: 1'b0};
							state_q <= S_FIN;
						end else begin
							mid_q   <= below ? mid_up : mid_dn;
							state_q <= S_MUL;
						end
					end
				end
				S_FIN: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign idle       = (state_q == S_IDLE);
	assign res_valid  = (state_q == S_FIN);
	assign res        = res_q;
	assign sq_en      = (state_q == S_MUL);
	assign sq_operand = mid_q;

	// The midpoint stays inside the window and the window never closes.
	`ASSERT_CLK(a_window_order, clk, arst_n,
		(state_q == S_MUL || state_q == S_CMP) |-> (low_q <= mid_q && mid_q < high_q),
		"bisection window out of order")
	// A search in progress has not used up its passes.
	`ASSERT_CLK(a_pass_bound, clk, arst_n,
		(state_q == S_MUL || state_q == S_CMP) |-> (pass_q < PassMax),
		"pass count beyond limit during search")
	// Every search reaches the compare right after its square is formed.
	`ASSERT_CLK(a_mul_then_cmp, clk, arst_n,
		(state_q == S_MUL) |=> (state_q == S_CMP),
		"square not followed by compare")

endmodule

### rtl/square_root_bisection.sv
// Square root of an unsigned fixed-point value (FRAC_BITS fraction bits) by
// bisection over [0, max(1.0, value)], using one shared 32x32 squarer. Each
// pass squares the midpoint into the squarer's output register, then compares
// and narrows the window; a search ends when the square is within tolerance
// or after MAX_PASSES passes, and a value of zero or exactly 1.0 finishes
// without any pass. One item is worked on at a time; the finished result sits
// in an output register, so the next value is taken while it waits. The user
// must write the tolerance register only while no item is in flight; the
// block itself does not enforce it.
module square_root_bisection import srb_pkg::*; #(
	parameter int unsigned MAX_PASSES = MAX_PASSES_DEF,
	parameter int unsigned FRAC_BITS  = FRAC_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              tol_we,
	input  logic [DATA_W-1:0] tolerance,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [DATA_W-1:0] value,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [DATA_W-1:0] root,
	output logic [PASS_W-1:0] pass_total,
	output logic              converged
);

	`include "assert_macros.svh"

	// 0.1 rounded to nearest in the chosen format.
	localparam logic [DATA_W-1:0] TolReset =
		DATA_W'(((64'd1 << FRAC_BITS) + 64'd5) / 64'd10);

	logic [DATA_W-1:0] tolerance_q;
	logic              out_valid_q;
	srb_result_t       out_q;

	logic              seq_idle;
	logic              res_valid;
	logic              res_ready;
	srb_result_t       res;
	logic              sq_en;
	logic [DATA_W-1:0] sq_operand;
	logic [SQ_W-1:0]   sq_product;

	// Tolerance register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tolerance_q <= TolReset;
		end else if (tol_we) begin
			tolerance_q <= tolerance;
		end
	end

	assign in_ready  = seq_idle;
	assign res_ready = !out_valid_q || out_ready;

	srb_seq #(
		.MAX_PASSES (MAX_PASSES),
		.FRAC_BITS  (FRAC_BITS)
	) u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (in_valid && in_ready),
		.value      (value),
		.tolerance  (tolerance_q),
		.idle       (seq_idle),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.res        (res),
		.sq_en      (sq_en),
		.sq_operand (sq_operand),
		.sq_product (sq_product)
	);

	srb_square u_square (
		.clk     (clk),
		.en      (sq_en),
		.operand (sq_operand),
		.product (sq_product)
	);

	// Output register: holds a finished beat until it is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
			if (res_valid) begin
				out_q <= res;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign root       = out_q.root;
	assign pass_total = out_q.passes;
	assign converged  = out_q.converged;

	// A result handed over always shows up on the output in the next cycle.
	`ASSERT_CLK(a_result_lands, clk, arst_n,
		(res_valid && res_ready) |=> out_valid,
		"finished result did not reach the output")
	// A search that failed to converge has used every pass.
	`ASSERT_CLK(a_fail_at_limit, clk, arst_n,
		(out_valid && !converged) |-> (pass_total == PASS_W'(MAX_PASSES)),
		"non-converged result before pass limit")
	// No new value is taken while a finished result is pending in the sequencer.
	`ASSERT_NEVER(a_no_overlap, clk, arst_n,
		in_ready && res_valid,
		"input ready while a result is pending in the sequencer")

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
	import srb_pkg::*;

	localparam int unsigned FRAC        = FRAC_BITS_DEF;
	localparam int unsigned PASS_LIMIT  = MAX_PASSES_DEF;
	localparam logic [31:0] ONE_FX      = 32'h1 << FRAC;
	localparam logic [31:0] TOL_AT_RST  = 32'd6554;
	localparam logic [31:0] TOL_MAX     = 32'hFFFF_FFFF;
	localparam int          QUIET_LIMIT = 2000;
	localparam int          LONG_HOLD   = 400;
	localparam int          HOLD_AT     = 300;
	localparam int          PHASES      = 7;
	localparam int          PHASE_BEATS = 250;
	localparam int          STEP_COUNT  = 22;

	// One directed step: an optional tolerance write, then one radicand.
	typedef struct packed {
		logic        set_tol;
		logic [31:0] tol;
		logic [31:0] val;
		logic        known;
		srb_result_t want;
	} step_t;

	localparam step_t STEPS [STEP_COUNT] = '{
		// Reset tolerance: zero, one, an exact midpoint, then extremes and other values.
		'{1'b0, 32'h0, 32'h0000_0000, 1'b1, '{32'h0000_0000, 6'd0, 1'b1}},
		'{1'b0, 32'h0, 32'h0001_0000, 1'b1, '{32'h0001_0000, 6'd0, 1'b1}},
		'{1'b0, 32'h0, 32'h0004_0000, 1'b1, '{32'h0002_0000, 6'd0, 1'b1}},
		'{1'b0, 32'h0, 32'hFFFF_FFFF, 1'b0, '0},
		'{1'b0, 32'h0, 32'h0000_0001, 1'b0, '0},
		'{1'b0, 32'h0, 32'h0000_FFFF, 1'b0, '0},
		'{1'b0, 32'h0, 32'h0001_0001, 1'b0, '0},
		'{1'b0, 32'h0, 32'h0002_0000, 1'b0, '0},
		'{1'b0, 32'h0, 32'h8000_0000, 1'b0, '0},
		'{1'b0, 32'h0, 32'hFFFE_0001, 1'b0, '0},
		// Zero tolerance: only exact squares converge, others run to the limit.
		'{1'b1, 32'h0, 32'h0000_0000, 1'b1, '{32'h0000_0000, 6'd0, 1'b1}},
		'{1'b0, 32'h0, 32'h0002_0000, 1'b0, '0},
		'{1'b0, 32'h0, 32'h0009_0000, 1'b0, '0},
		'{1'b0, 32'h0, 32'hFFFF_FFFF, 1'b0, '0},
		'{1'b0, 32'h0, 32'h0001_0000, 1'b1, '{32'h0001_0000, 6'd0, 1'b1}},
		// Largest tolerance.
		'{1'b1, TOL_MAX, 32'h0001_2345, 1'b0, '0},
		'{1'b0, TOL_MAX, 32'hFFFF_FFFF, 1'b0, '0},
		'{1'b0, TOL_MAX, 32'h0000_0000, 1'b1, '{32'h0000_0000, 6'd0, 1'b1}},
		// Smallest non-zero tolerance.
		'{1'b1, 32'h1, 32'hDEAD_BEEF, 1'b0, '0},
		'{1'b0, 32'h1, 32'h0000_0002, 1'b0, '0},
		'{1'b0, 32'h1, 32'h0004_0000, 1'b1, '{32'h0002_0000, 6'd0, 1'b1}},
		// Back to the reset tolerance.
		'{1'b1, TOL_AT_RST, 32'h7FFF_FFFF, 1'b0, '0}
	};

	logic              clk;
	logic              arst_n;
	logic              tol_we;
	logic [DATA_W-1:0] tolerance;
	logic              in_valid;
	logic              in_ready;
	logic [DATA_W-1:0] value;
	logic              out_valid;
	logic              out_ready;
	logic [DATA_W-1:0] root;
	logic [PASS_W-1:0] pass_total;
	logic              converged;

	srb_result_t roots_due [$];
	logic [31:0] tol_now;
	bit          burst;
	int          errors;
	int          roots_seen;
	int          quiet;

	square_root_bisection dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.tol_we     (tol_we),
		.tolerance  (tolerance),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.value      (value),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.root       (root),
		.pass_total (pass_total),
		.converged  (converged)
	);

	always #2 clk = ~clk;

	// Bisection search as the block performs it, with exact 64-bit squares.
	function automatic srb_result_t sqrt_bisect(input logic [31:0] v, input logic [31:0] tol);
		logic [63:0] goal;
		logic [63:0] slack;
		logic [63:0] sq;
		logic [63:0] gap;
		logic [32:0] sum;
		logic [31:0] lo;
		logic [31:0] hi;
		logic [31:0] mid;
		logic [31:0] found;
		int          n;
		bit          hit;
		srb_result_t r;
		goal  = {32'b0, v} << FRAC;
		slack = {32'b0, tol} << FRAC;
		lo    = '0;
		hi    = (v > ONE_FX) ? v : ONE_FX;
		mid   = '0;
		found = '0;
		n     = 0;
		hit   = 0;
		while (!hit && n < PASS_LIMIT) begin
			if ({32'b0, lo} * {32'b0, lo} == goal) begin
				found = lo;
				hit   = 1;
			end else if ({32'b0, hi} * {32'b0, hi} == goal) begin
				found = hi;
				hit   = 1;
			end else begin
				sum = {1'b0, lo} + {1'b0, hi};
				mid = sum[32:1];
				sq  = {32'b0, mid} * {32'b0, mid};
				gap = (sq >= goal) ? sq - goal : goal - sq;
				if (gap <= slack) begin
					found = mid;
					hit   = 1;
				end else if (sq < goal) begin
					lo = mid;
				end else begin
					hi = mid;
				end
			end
			if (!hit)
				n++;
		end
		r.root      = hit ? found : mid;
		r.passes    = PASS_W'(n);
		r.converged = hit;
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("%0t: mismatch on %s: got %h, expected %h", $realtime, what, got, want);
		errors++;
	endtask

	// Offers one radicand after a random gap (none in a burst) and records the root it should give.
	task automatic offer(input logic [31:0] v, input logic known, input srb_result_t want);
		int gap;
		gap = burst ? 0 : $urandom_range(0, 4);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		value    <= v;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		roots_due.push_back(known ? want : sqrt_bisect(v, tol_now));
	endtask

	// The tolerance is only changed once every outstanding root has been returned.
	task automatic write_tolerance(input logic [31:0] t);
		in_valid <= 1'b0;
		while (roots_due.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		tol_we    <= 1'b1;
		tolerance <= t;
		@(posedge clk);
		tol_we  <= 1'b0;
		tol_now = t;
	endtask

	// Stimulus: reset, the directed steps, then random phases.
	initial begin
		logic [31:0] v;
		logic [31:0] t;
		int          j;
		clk       = 1'b0;
		arst_n    = 1'b0;
		tol_we    = 1'b0;
		tolerance = '0;
		in_valid  = 1'b0;
		value     = '0;
		out_ready = 1'b0;
		tol_now   = TOL_AT_RST;
		burst     = 0;
		errors    = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (STEPS[i]) begin
			if (STEPS[i].set_tol)
				write_tolerance(STEPS[i].tol);
			offer(STEPS[i].val, STEPS[i].known, STEPS[i].want);
		end

		for (int ph = 0; ph < PHASES; ph++) begin
			case ($urandom_range(0, 5))
				0: t = '0;
				1: t = TOL_MAX;
				2: t = $urandom;
				3: t = $urandom_range(0, 32'hFFFF);
				4: t = $urandom_range(0, 255);
				default: t = TOL_AT_RST;
			endcase
			write_tolerance(t);
			for (int k = 0; k < PHASE_BEATS; k++) begin
				// Back-to-back stretches alternate with randomly gapped beats.
				burst = (k % 64) < 12;
				j = $urandom_range(0, 65535);
				case ($urandom_range(0, 9))
					0, 1, 2, 3: v = $urandom;
					4, 5: v = $urandom_range(0, 32'h3_0000);
					6: v = j * j;
					7: v = j * j + $urandom_range(0, 2) - 1;
					8: v = $urandom >> $urandom_range(0, 31);
					default: begin
						case ($urandom_range(0, 3))
							0: v = '0;
							1: v = ONE_FX;
							2: v = 32'h1;
							default: v = 32'hFFFF_FFFF;
						endcase
					end
				endcase
				offer(v, 1'b0, '0);
			end
		end

		// Drain and let the block settle before the verdict.
		in_valid <= 1'b0;
		while (roots_due.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	// Result side: random stalls, one long hold-off, and every beat checked in order.
	initial begin
		int          hold;
		srb_result_t want;
		roots_seen = 0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			hold = ((roots_seen % 128) < 32) ? 0 : $urandom_range(0, 4);
			if (roots_seen == HOLD_AT)
				hold = LONG_HOLD;
			if (hold != 0) begin
				out_ready <= 1'b0;
				repeat (hold) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid)
				@(posedge clk);
			if (roots_due.size() == 0) begin
				report_mismatch("unexpected root", root, '0);
			end else begin
				want = roots_due.pop_front();
				if (root !== want.root)
					report_mismatch("root", root, want.root);
				if (pass_total !== want.passes)
					report_mismatch("pass_total", 32'(pass_total), 32'(want.passes));
				if (converged !== want.converged)
					report_mismatch("converged", 32'(converged), 32'(want.converged));
			end
			roots_seen++;
		end
	end

	// Watchdog: ends the run if no beat moves on either side for too long.
	initial quiet = 0;
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet = 0;
		else
			quiet++;
		if (quiet >= QUIET_LIMIT) begin
			$display("%0t: no beat for %0d cycles", $realtime, QUIET_LIMIT);
			$display("== FAIL ==");
			$finish;
		end
	end

endmodule
